FILE: design/can_fragment_reassembler_core_assert.svh
// Assertion macros shared by the CAN fragment reassembler modules.
// Each macro expects clk and rst_n to be visible in the including module.
`ifndef CAN_FRAGMENT_REASSEMBLER_CORE_ASSERT_SVH
`define CAN_FRAGMENT_REASSEMBLER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define CFR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define CFR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/can_frag_pkg.sv
// Shared types and constants of the CAN fragment reassembler.
// No dependencies; used by the interfaces and all modules.
package can_frag_pkg;

  localparam int BYTE_W          = 8;
  localparam int ID_W            = 32;
  localparam int LEN_W           = 4;
  localparam int PAY_BYTES       = 7;
  localparam int FRAME_BYTES_MAX = 8;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_ID = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE = CFG_IDX_W'(1);

  localparam logic [ID_W-1:0]   MATCH_ID_RST = '0;
  localparam logic [BYTE_W-1:0] END_BYTE_RST = BYTE_W'(10);

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_OOO   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] msg_byte;
    logic              last;
    logic [BYTE_W-1:0] want_index;
    logic [BYTE_W-1:0] got_index;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REPORT,
    ST_SCAN,
    ST_EMIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

FILE: design/can_frag_ifs.sv
// Valid/ready channel interfaces: received frames, result items, config writes.
// Depends on can_frag_pkg for field widths.
interface can_frag_in_if;
  logic                               valid;
  logic                               ready;
  logic [can_frag_pkg::ID_W-1:0]      frame_id;
  logic [can_frag_pkg::LEN_W-1:0]     frame_len;
  logic [can_frag_pkg::BYTE_W-1:0]    seq_index;
  logic [can_frag_pkg::BYTE_W-1:0]    pay1;
  logic [can_frag_pkg::BYTE_W-1:0]    pay2;
  logic [can_frag_pkg::BYTE_W-1:0]    pay3;
  logic [can_frag_pkg::BYTE_W-1:0]    pay4;
  logic [can_frag_pkg::BYTE_W-1:0]    pay5;
  logic [can_frag_pkg::BYTE_W-1:0]    pay6;
  logic [can_frag_pkg::BYTE_W-1:0]    pay7;

  modport source (output valid, frame_id, frame_len, seq_index,
                  pay1, pay2, pay3, pay4, pay5, pay6, pay7, input ready);
  modport sink   (input valid, frame_id, frame_len, seq_index,
                  pay1, pay2, pay3, pay4, pay5, pay6, pay7, output ready);
endinterface

interface can_frag_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      kind;
  logic [can_frag_pkg::BYTE_W-1:0] msg_byte;
  logic                            last;
  logic [can_frag_pkg::BYTE_W-1:0] want_index;
  logic [can_frag_pkg::BYTE_W-1:0] got_index;

  modport source (output valid, kind, msg_byte, last, want_index, got_index,
                  input ready);
  modport sink   (input valid, kind, msg_byte, last, want_index, got_index,
                  output ready);
endinterface

interface can_frag_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [can_frag_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [can_frag_pkg::CFG_DATA_W-1:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

FILE: design/can_frag_store.sv
// Message byte store: single write port, single read port, registered read data.
// Depends on can_frag_pkg for the byte width and the control struct.
module can_frag_store #(
  parameter int MAX_BYTES = 64
) (
  input  logic                                       clk,
  input  can_frag_pkg::mem_ctl_t                     mem_ctl,
  input  logic [$clog2(MAX_BYTES)-1:0]               waddr,
  input  logic [can_frag_pkg::BYTE_W-1:0]            wdata,
  input  logic [$clog2(MAX_BYTES)-1:0]               raddr,
  output logic [can_frag_pkg::BYTE_W-1:0]            rdata
);

  logic [can_frag_pkg::BYTE_W-1:0] mem [MAX_BYTES];
  logic [can_frag_pkg::BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read is issued
  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/can_frag_ctrl.sv
// Frame sequencer: index check, payload scan into the store, message readout,
// and the result output register. Depends on can_frag_pkg, the channel
// interfaces and the assertion macro header.
`include "can_fragment_reassembler_core_assert.svh"

module can_frag_ctrl #(
  parameter int MAX_BYTES = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  can_frag_in_if.sink                         in_ch,
  can_frag_out_if.source                      out_ch,
  input  logic [can_frag_pkg::ID_W-1:0]       match_id,
  input  logic [can_frag_pkg::BYTE_W-1:0]     end_byte,
  output can_frag_pkg::mem_ctl_t              mem_ctl,
  output logic [$clog2(MAX_BYTES)-1:0]        mem_waddr,
  output logic [can_frag_pkg::BYTE_W-1:0]     mem_wdata,
  output logic [$clog2(MAX_BYTES)-1:0]        mem_raddr,
  input  logic [can_frag_pkg::BYTE_W-1:0]     mem_rdata
);

  localparam int AW = $clog2(MAX_BYTES);
  localparam logic [AW-1:0] FILL_MAX = AW'(MAX_BYTES - 1);
  localparam int BW = can_frag_pkg::BYTE_W;
  localparam int LW = can_frag_pkg::LEN_W;
  localparam int NP = can_frag_pkg::PAY_BYTES;

  can_frag_pkg::state_t    state_r, state_nxt;
  logic [AW-1:0]           fill_r, fill_nxt;
  logic [BW-1:0]           next_index_r, next_index_nxt;
  logic [LW-1:0]           cnt_r, cnt_nxt;
  logic [LW-1:0]           len_r;
  logic [BW-1:0]           seq_r;
  logic [BW-1:0]           pay_r [NP];
  logic                    shift;
  logic [AW-1:0]           ptr_r, ptr_nxt;
  logic                    pend_r, pend_nxt;
  logic [BW-1:0]           hold_r, hold_nxt;
  logic                    hold_vld_r, hold_vld_nxt;
  logic                    out_vld_r, out_vld_nxt;
  can_frag_pkg::out_item_t out_item_r, out_item_nxt;
  logic                    push;
  can_frag_pkg::out_item_t push_item;

  logic in_acc, id_hit, idx_hit, out_free, scan_done, is_end, rd_more, rd_zero;

  assign in_ch.ready = (state_r == can_frag_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign id_hit      = (in_ch.frame_id == match_id);
  assign idx_hit     = (in_ch.seq_index == next_index_r);
  assign out_free    = !out_vld_r || out_ch.ready;
  assign scan_done   = (cnt_r >= len_r);
  assign is_end      = (pay_r[0] == end_byte);
  assign rd_more     = (ptr_r < fill_r);
  assign rd_zero     = (mem_rdata == '0);

  assign mem_waddr = fill_r;
  assign mem_wdata = pay_r[0];
  assign mem_raddr = ptr_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      can_frag_pkg::ST_IDLE: begin
        if (in_acc && id_hit) begin
          state_nxt = idx_hit ? can_frag_pkg::ST_SCAN : can_frag_pkg::ST_REPORT;
        end
      end
      can_frag_pkg::ST_REPORT: begin
        if (out_free) state_nxt = can_frag_pkg::ST_IDLE;
      end
      can_frag_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = can_frag_pkg::ST_IDLE;
        end else if (is_end) begin
          state_nxt = can_frag_pkg::ST_EMIT;
        end
      end
      can_frag_pkg::ST_EMIT: begin
        if (pend_r ? rd_zero : !rd_more) state_nxt = can_frag_pkg::ST_FINISH;
      end
      can_frag_pkg::ST_FINISH: begin
        if (out_free) state_nxt = can_frag_pkg::ST_IDLE;
      end
      default: state_nxt = can_frag_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    fill_nxt       = fill_r;
    next_index_nxt = next_index_r;
    cnt_nxt        = cnt_r;
    ptr_nxt        = ptr_r;
    pend_nxt       = pend_r;
    hold_nxt       = hold_r;
    hold_vld_nxt   = hold_vld_r;
    shift          = 1'b0;
    mem_ctl        = '0;
    push           = 1'b0;
    push_item      = '0;
    unique case (state_r)
      can_frag_pkg::ST_IDLE: begin
        cnt_nxt = LW'(1);
      end
      can_frag_pkg::ST_REPORT: begin
        if (out_free) begin
          push                 = 1'b1;
          push_item.kind       = can_frag_pkg::KIND_OOO;
          push_item.last       = 1'b1;
          push_item.want_index = next_index_r;
          push_item.got_index  = seq_r;
        end
      end
      can_frag_pkg::ST_SCAN: begin
        if (scan_done) begin
          next_index_nxt = next_index_r + BW'(1);
        end else if (is_end) begin
          ptr_nxt      = '0;
          pend_nxt     = 1'b0;
          hold_vld_nxt = 1'b0;
        end else begin
          // Drop bytes once the fill count reaches FILL_MAX (MAX_BYTES - 1)
          if (fill_r != FILL_MAX) begin
            mem_ctl.wr_en = 1'b1;
            fill_nxt      = fill_r + AW'(1);
          end
          cnt_nxt = cnt_r + LW'(1);
          shift   = 1'b1;
        end
      end
      can_frag_pkg::ST_EMIT: begin
        if (pend_r) begin
          // Hold one byte back so the last flag is known when it leaves
          if (!rd_zero && (!hold_vld_r || out_free)) begin
            if (hold_vld_r) begin
              push               = 1'b1;
              push_item.kind     = can_frag_pkg::KIND_BYTE;
              push_item.msg_byte = hold_r;
            end
            hold_nxt     = mem_rdata;
            hold_vld_nxt = 1'b1;
            if (rd_more) begin
              mem_ctl.rd_en = 1'b1;
              ptr_nxt       = ptr_r + AW'(1);
            end else begin
              pend_nxt = 1'b0;
            end
          end
        end else if (rd_more) begin
          mem_ctl.rd_en = 1'b1;
          ptr_nxt       = ptr_r + AW'(1);
          pend_nxt      = 1'b1;
        end
      end
      can_frag_pkg::ST_FINISH: begin
        if (out_free) begin
          push           = 1'b1;
          push_item.last = 1'b1;
          if (hold_vld_r) begin
            push_item.kind     = can_frag_pkg::KIND_BYTE;
            push_item.msg_byte = hold_r;
          end else begin
            push_item.kind = can_frag_pkg::KIND_EMPTY;
          end
          fill_nxt       = '0;
          next_index_nxt = '0;
          hold_vld_nxt   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_item_nxt = push ? push_item : out_item_r;
    if (push) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= can_frag_pkg::ST_IDLE;
      fill_r       <= '0;
      next_index_r <= '0;
      pend_r       <= 1'b0;
      hold_vld_r   <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      next_index_r <= next_index_nxt;
      pend_r       <= pend_nxt;
      hold_vld_r   <= hold_vld_nxt;
      out_vld_r    <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    ptr_r      <= ptr_nxt;
    hold_r     <= hold_nxt;
    out_item_r <= out_item_nxt;
  end

  // Capture the frame; during the scan advance the payload one byte a cycle
  always_ff @(posedge clk) begin
    if (in_acc) begin
      len_r    <= (in_ch.frame_len > LW'(can_frag_pkg::FRAME_BYTES_MAX)) ?
                  LW'(can_frag_pkg::FRAME_BYTES_MAX) : in_ch.frame_len;
      seq_r    <= in_ch.seq_index;
      pay_r[0] <= in_ch.pay1;
      pay_r[1] <= in_ch.pay2;
      pay_r[2] <= in_ch.pay3;
      pay_r[3] <= in_ch.pay4;
      pay_r[4] <= in_ch.pay5;
      pay_r[5] <= in_ch.pay6;
      pay_r[6] <= in_ch.pay7;
    end else if (shift) begin
      for (int i = 0; i < NP - 1; i++) begin
        pay_r[i] <= pay_r[i+1];
      end
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.kind       = out_item_r.kind;
  assign out_ch.msg_byte   = out_item_r.msg_byte;
  assign out_ch.last       = out_item_r.last;
  assign out_ch.want_index = out_item_r.want_index;
  assign out_ch.got_index  = out_item_r.got_index;

  `CFR_ASSERT_IMP(a_push_room, push, out_free, "result pushed while output register is stalled")
  `CFR_ASSERT_IMP(a_wr_not_full, mem_ctl.wr_en, (fill_r != FILL_MAX) && !mem_ctl.rd_en, "store write past capacity")
  `CFR_ASSERT_IMP(a_rd_in_fill, mem_ctl.rd_en, ptr_r < fill_r, "store read beyond filled bytes")
  `CFR_ASSERT_NXT(a_finish_clears, (state_r == can_frag_pkg::ST_FINISH) && out_free, (fill_r == '0) && (next_index_r == '0) && (state_r == can_frag_pkg::ST_IDLE), "completion did not clear state")

endmodule

FILE: design/can_fragment_reassembler_core.sv
// CAN fragment reassembler, top level.
// in_ch takes one received frame per item (valid/ready); frames whose id
// differs from register 0 (match_id) are dropped. Byte one of a frame is the
// sequence index; a wrong index gives one out-of-order result on out_ch.
// In-order payload bytes go to a message store until the register 1
// terminator (end_byte) arrives; the stored message, up to its first zero
// byte, then leaves on out_ch one byte per item, last set on the final one.
// cfg_ch writes registers (index, data) and is always ready.
// A frame is taken in the cycle in_ch.ready is high and is worked on
// alone; its length is clamped to 8. In-order payload bytes pass the
// store's write port one payload byte per cycle. A terminated message is
// read out with one store read per cycle while the output register is
// not stalled.
// A one-entry output register decouples the result side: when out_ch stalls,
// work holds at the next result and in_ch.ready stays low until the final
// result of the frame has entered the output register.
// Reset (rst_n, synchronous) clears the fill count and expected index and
// restores the register defaults; the store needs no clearing.
module can_fragment_reassembler_core #(
  parameter int MAX_BYTES = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  can_frag_in_if.sink    in_ch,
  can_frag_out_if.source out_ch,
  can_frag_cfg_if.sink   cfg_ch
);

  localparam int AW = $clog2(MAX_BYTES);

  logic [can_frag_pkg::ID_W-1:0]   match_id_r, match_id_nxt;
  logic [can_frag_pkg::BYTE_W-1:0] end_byte_r, end_byte_nxt;
  can_frag_pkg::mem_ctl_t          mem_ctl;
  logic [AW-1:0]                   mem_waddr, mem_raddr;
  logic [can_frag_pkg::BYTE_W-1:0] mem_wdata, mem_rdata;

  assign cfg_ch.ready = 1'b1;

  // Register decode; unknown indexes are ignored
  always_comb begin
    match_id_nxt = match_id_r;
    end_byte_nxt = end_byte_r;
    if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.reg_index)
        can_frag_pkg::REG_MATCH_ID: match_id_nxt = cfg_ch.wr_data;
        can_frag_pkg::REG_END_BYTE:
          end_byte_nxt = cfg_ch.wr_data[can_frag_pkg::BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_id_r <= can_frag_pkg::MATCH_ID_RST;
      end_byte_r <= can_frag_pkg::END_BYTE_RST;
    end else begin
      match_id_r <= match_id_nxt;
      end_byte_r <= end_byte_nxt;
    end
  end

  can_frag_ctrl #(
    .MAX_BYTES (MAX_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .match_id  (match_id_r),
    .end_byte  (end_byte_r),
    .mem_ctl   (mem_ctl),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  can_frag_store #(
    .MAX_BYTES (MAX_BYTES)
  ) u_store (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rdata   (mem_rdata)
  );

endmodule
